// ----- rtl/ffca_pkg.sv -----
`default_nettype none

package ffca_pkg;

  // Default geometry
  localparam int UNITS_DEF      = 2048;
  localparam int OWNER_BITS_DEF = 8;

  // Payload field widths
  localparam int OPCODE_W   = 1;
  localparam int OWNER_ID_W = 8;
  localparam int SIZE_W     = 12;
  localparam int STATUS_W   = 2;
  localparam int ADDR_W     = 11;
  localparam int PCT_W      = 7;

  // Percent scale
  localparam int PCT_SCALE = 100;

  // Request opcodes
  localparam logic [OPCODE_W-1:0] OP_ALLOC   = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 1'b1;

  // Result codes
  typedef enum logic [STATUS_W-1:0] {
    ST_NEW      = 2'd0,
    ST_HELD     = 2'd1,
    ST_NOFIT    = 2'd2,
    ST_RELEASED = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ----- rtl/ffca_if.sv -----
`default_nettype none

// Request channel
interface ffca_req_if;
  import ffca_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [OWNER_ID_W-1:0] owner_id;
  logic [SIZE_W-1:0]     size;

  modport source (output valid, output opcode, output owner_id, output size, input ready);
  modport sink   (input valid, input opcode, input owner_id, input size, output ready);
endinterface

// Result channel
interface ffca_rsp_if;
  import ffca_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [ADDR_W-1:0]   address;
  logic [PCT_W-1:0]    usage_percent;

  modport source (output valid, output status, output address, output usage_percent,
                  input ready);
  modport sink   (input valid, input status, input address, input usage_percent,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/ffca_ram.sv -----
`default_nettype none

// Simple dual-port RAM, one write port, one registered read port.
module ffca_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 8,
  parameter int AW    = 11
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/ffca_usage.sv -----
`default_nettype none

// Occupancy percent, rounded up: ceil(used*100/UNITS).
// Reciprocal multiply gives the quotient or one less; one compare fixes it.
// done pulses once start has passed through s1 and s2; pct holds until the next start.
module ffca_usage #(
  parameter int UNITS = 2048,
  parameter int UW    = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [UW-1:0]              used,
  output logic                       done,
  output logic [ffca_pkg::PCT_W-1:0] pct
);
  import ffca_pkg::*;

  // numerator used*100 + UNITS-1 stays below 2**XW
  localparam int            XW      = $clog2(UNITS * (PCT_SCALE + 1));
  localparam int            MW      = 2 * XW;
  localparam longint        RECIP_L = (longint'(1) << XW) / longint'(UNITS);
  localparam logic [XW-1:0] RECIP   = XW'(RECIP_L);

  logic             s1;
  logic             s2;
  logic [XW-1:0]    num;
  logic [MW-1:0]    prod;
  logic [PCT_W-1:0] q0;     // true quotient or one less
  logic [XW-1:0]    back;
  logic [XW-1:0]    rem;

  assign q0   = prod[XW +: PCT_W];
  assign back = XW'(q0) * XW'(UNITS);
  assign rem  = num - back;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= 1'b0;
      s2   <= 1'b0;
      done <= 1'b0;
    end else begin
      s1   <= start;
      s2   <= s1;
      done <= s2;
    end
    if (start) begin
      num <= XW'(used) * XW'(PCT_SCALE) + XW'(UNITS - 1);
    end
    if (s1) begin
      prod <= MW'(num) * MW'(RECIP);
    end
    if (s2) begin
      pct <= (rem >= XW'(UNITS)) ? q0 + 1'b1 : q0;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/first_fit_contiguous_allocator.sv -----
`default_nettype none

// Channel  Dir  Modport  Payload
// req      in   sink     opcode, owner_id, size
// rsp      out  source   status, address, usage_percent
//
// Per request: an owner/first-fit scan through the owner map RAM (one entry a
// cycle, single read port), then tagging of a new block (single write port),
// then the percent unit, then a load of the output register. A tag-0 request
// skips the scan. Reset is synchronous; afterwards a clearing pass zeroes
// every RAM entry with req.ready low.
// Results sit in an output register; a stalled rsp holds the block after its
// next request, which is still accepted while a result waits.
module first_fit_contiguous_allocator #(
  parameter int UNITS      = ffca_pkg::UNITS_DEF,
  parameter int OWNER_BITS = ffca_pkg::OWNER_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  ffca_req_if.sink   req,
  ffca_rsp_if.source rsp
);
  import ffca_pkg::*;

  localparam int AW = (UNITS > 1) ? $clog2(UNITS) : 1;
  localparam int UW = $clog2(UNITS + 1);
  localparam int CW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  localparam logic [AW-1:0] LAST = AW'(UNITS - 1);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_FILL, S_PCT, S_DONE
  } state_t;

  state_t                state;
  logic [AW-1:0]         idx;        // read / fill / clear pointer
  logic                  issuing;    // scan reads still going out
  logic                  rd_vld;     // RAM data valid this cycle
  logic [AW-1:0]         rd_idx;     // entry that rdata belongs to
  logic [OPCODE_W-1:0]   op;
  logic [OWNER_BITS-1:0] tag;
  logic [SIZE_W-1:0]     size;
  logic                  placed;
  logic [SIZE_W-1:0]     run;
  logic [AW-1:0]         base;
  logic [SIZE_W-1:0]     fcnt;
  status_t               status;
  logic [UW-1:0]         used;
  logic                  pct_start;

  logic                  rsp_valid;
  status_t               rsp_status;
  logic [ADDR_W-1:0]     rsp_addr;
  logic [PCT_W-1:0]      rsp_pct;

  // RAM and percent unit hookup
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [OWNER_BITS-1:0] ram_wdata;
  logic [OWNER_BITS-1:0] ram_rdata;
  logic                  pct_done;
  logic [PCT_W-1:0]      pct_val;

  ffca_ram #(
    .DEPTH (UNITS),
    .WIDTH (OWNER_BITS),
    .AW    (AW)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  ffca_usage #(
    .UNITS (UNITS),
    .UW    (UW)
  ) u_usage (
    .clk   (clk),
    .rst   (rst),
    .start (pct_start),
    .used  (used),
    .done  (pct_done),
    .pct   (pct_val)
  );

  // Scan-stage decode of the entry coming out of the RAM
  logic          hit;       // entry carries this owner
  logic          fit_now;   // this free entry completes the first run
  logic          scan_end;
  logic [AW-1:0] fit_base;

  assign hit      = rd_vld && (ram_rdata == tag);
  assign fit_now  = rd_vld && (ram_rdata == '0) && !placed &&
                    ({1'b0, run} + 1'b1 == {1'b0, size});
  assign scan_end = rd_vld && (rd_idx == LAST);
  assign fit_base = placed ? base : AW'(CW'(rd_idx) + CW'(1) - CW'(size));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_SCAN: begin
        // release clears matching entries behind the read pointer
        ram_we    = hit && (op == OP_RELEASE);
        ram_waddr = rd_idx;
      end
      S_FILL: begin
        ram_we    = 1'b1;
        ram_wdata = tag;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = rsp_valid;
  assign rsp.status        = rsp_status;
  assign rsp.address       = rsp_addr;
  assign rsp.usage_percent = rsp_pct;

  always_ff @(posedge clk) begin
    pct_start <= 1'b0;
    if (rsp_valid && rsp.ready) begin
      rsp_valid <= 1'b0;
    end

    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      issuing   <= 1'b0;
      rd_vld    <= 1'b0;
      used      <= '0;
      rsp_valid <= 1'b0;
      pct_start <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: begin
          if (idx == LAST) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        S_IDLE: begin
          if (req.valid) begin
            op     <= req.opcode;
            tag    <= OWNER_BITS'(req.owner_id);
            size   <= req.size;
            placed <= 1'b0;
            run    <= '0;
            base   <= '0;
            idx    <= '0;
            if (OWNER_BITS'(req.owner_id) == '0) begin
              // tag 0 means free: nothing to scan
              status    <= (req.opcode == OP_RELEASE) ? ST_RELEASED : ST_NOFIT;
              pct_start <= 1'b1;
              state     <= S_PCT;
            end else begin
              issuing <= 1'b1;
              state   <= S_SCAN;
            end
          end
        end

        S_SCAN: begin
          if (issuing) begin
            rd_vld <= 1'b1;
            rd_idx <= idx;
            if (idx == LAST) begin
              idx     <= '0;
              issuing <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
            end
          end else begin
            rd_vld <= 1'b0;
          end

          if (rd_vld) begin
            if (op == OP_RELEASE) begin
              if (hit) begin
                used <= used - 1'b1;
              end
              if (scan_end) begin
                status    <= ST_RELEASED;
                pct_start <= 1'b1;
                state     <= S_PCT;
              end
            end else begin
              if (ram_rdata != '0) begin
                run <= '0;
              end else if (!placed) begin
                if (fit_now) begin
                  placed <= 1'b1;
                  base   <= fit_base;
                end else begin
                  run <= run + 1'b1;
                end
              end

              if (hit) begin
                // owner already holds units: lowest one wins, stop early
                base      <= rd_idx;
                status    <= ST_HELD;
                pct_start <= 1'b1;
                state     <= S_PCT;
              end else if (scan_end) begin
                if (placed || fit_now) begin
                  base  <= fit_base;
                  idx   <= fit_base;
                  fcnt  <= size;
                  state <= S_FILL;
                end else begin
                  status    <= ST_NOFIT;
                  pct_start <= 1'b1;
                  state     <= S_PCT;
                end
              end
            end

            if (hit && (op != OP_RELEASE) || scan_end) begin
              issuing <= 1'b0;
              rd_vld  <= 1'b0;
              if (hit && (op != OP_RELEASE)) begin
                idx <= '0;
              end
            end
          end
        end

        S_FILL: begin
          idx  <= idx + 1'b1;
          fcnt <= fcnt - 1'b1;
          if (fcnt == SIZE_W'(1)) begin
            idx       <= '0;
            used      <= used + UW'(size);
            status    <= ST_NEW;
            pct_start <= 1'b1;
            state     <= S_PCT;
          end
        end

        S_PCT: begin
          if (pct_done) begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid  <= 1'b1;
            rsp_status <= status;
            rsp_addr   <= ((status == ST_NEW) || (status == ST_HELD)) ?
                          ADDR_W'(base) : '0;
            rsp_pct    <= pct_val;
            state      <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // A release write must never land on the entry being read.
  a_scan_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state == S_SCAN) |-> (ram_waddr != idx))
    else $error("scan write collides with read address");

  // Occupancy never exceeds the map size.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used <= UW'(UNITS))
    else $error("used count beyond UNITS");

  // The percent unit only finishes while a result is waiting for it.
  a_pct_done_state: assert property (@(posedge clk) disable iff (rst)
    pct_done |-> (state == S_PCT))
    else $error("percent result outside wait state");

  // A loaded release or no-fit result carries a zero address.
  a_rsp_addr_zero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!rsp_valid || rsp.ready) &&
     (status == ST_RELEASED || status == ST_NOFIT)) |=> (rsp_addr == '0))
    else $error("nonzero address on release or no-fit");

endmodule

`default_nettype wire
